// ===== sv/pss_pkg.sv =====
// pump switch sequencer: shared types and constants
// no dependencies; used by every other file of the block but pss_if
`default_nettype none

package pss_pkg;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_RELAY_ON  = 4'd1,
        ST_TRIAC_ON  = 4'd2,
        ST_WATER     = 4'd3,
        ST_DELAY     = 4'd4,
        ST_TRIAC_OFF = 4'd5,
        ST_RELAY_OFF = 4'd6
    } t_state;

    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_ENABLE    = 3'd1;
    localparam logic [2:0] OP_DISABLE   = 3'd2;
    localparam logic [2:0] OP_DRAIN     = 3'd3;
    localparam logic [2:0] OP_DRAIN_WET = 3'd4;
    localparam logic [2:0] OP_TEST      = 3'd5;

    localparam logic [2:0] FLT_NONE         = 3'd0;
    localparam logic [2:0] FLT_NO_FB_RELAY  = 3'd1;
    localparam logic [2:0] FLT_FB_TRIAC_ON  = 3'd2;
    localparam logic [2:0] FLT_NO_FB_TRIAC  = 3'd3;
    localparam logic [2:0] FLT_FB_RELAY_OFF = 3'd4;
    localparam logic [2:0] FLT_CANCELLED    = 3'd5;

    localparam logic [2:0] REG_STEP_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_GAP_MIN      = 3'd1;
    localparam logic [2:0] REG_GAP_MAX      = 3'd2;
    localparam logic [2:0] REG_LOSS_GAP     = 3'd3;
    localparam logic [2:0] REG_TEST_DRAIN   = 3'd4;

    localparam logic [15:0] RST_STEP_TIMEOUT = 16'd1000;
    localparam logic [7:0]  RST_GAP_MIN      = 8'd8;
    localparam logic [7:0]  RST_GAP_MAX      = 8'd12;
    localparam logic [7:0]  RST_LOSS_GAP     = 8'd13;
    localparam logic [15:0] RST_TEST_DRAIN   = 16'd15000;

    localparam logic [7:0]  GAP_SAT  = 8'hFF;
    localparam logic [15:0] WAIT_SAT = 16'hFFFF;

    typedef struct packed {
        logic [15:0] step_timeout_ms;
        logic [7:0]  pulse_gap_min_ms;
        logic [7:0]  pulse_gap_max_ms;
        logic [7:0]  loss_gap_ms;
        logic [15:0] test_drain_ms;
    } t_cfg;

    typedef struct packed {
        logic       relay_drive;
        logic       triac_drive;
        logic       busy;
        logic       done;
        logic       success;
        logic [2:0] fault_code;
    } t_seq_res;

endpackage

`default_nettype wire

// ===== sv/pss_if.sv =====
// pump switch sequencer: valid/ready channel interfaces
// input tick, result and configuration write channels; no dependencies
`default_nettype none

interface pss_in_if;
    logic        valid;
    logic        ready;
    logic        feedback_pulse;
    logic        water_present;
    logic        cancel;
    logic [2:0]  opcode;
    logic [15:0] drain_ms;

    modport source (output valid, feedback_pulse, water_present, cancel, opcode, drain_ms,
                    input ready);
    modport sink   (input valid, feedback_pulse, water_present, cancel, opcode, drain_ms,
                    output ready);
endinterface

interface pss_out_if;
    logic       valid;
    logic       ready;
    logic       relay_drive;
    logic       triac_drive;
    logic       feedback_ok;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [2:0] fault_code;

    modport source (output valid, relay_drive, triac_drive, feedback_ok, busy_res,
                    done_res, success, fault_code, input ready);
    modport sink   (input valid, relay_drive, triac_drive, feedback_ok, busy_res,
                    done_res, success, fault_code, output ready);
endinterface

interface pss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/pump_switch_sequencer_with_feedback.sv =====
// Pump switch sequencer with pulse feedback. Each input beat is one millisecond
// tick and yields exactly one result beat. The feedback detector and the command
// state machine update in the same cycle the tick is accepted, and the result is
// held in an output register, so the block takes one tick per clock cycle; it
// stalls only while a result waits in the output register and the sink is not
// ready. Configuration writes are always taken and should be issued only while
// no command runs.
// depends on pss_pkg, pss_if, pss_fb_det and pss_seq
`default_nettype none

module pump_switch_sequencer_with_feedback
    import pss_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pss_in_if.sink     i_in,
    pss_out_if.source  o_out,
    pss_cfg_if.sink    i_cfg
);

    t_cfg     r_cfg;
    logic     tick_acc;
    logic     fb_next;
    t_seq_res seq_res;

    logic       r_out_valid;
    logic       r_relay;
    logic       r_triac;
    logic       r_fb_ok;
    logic       r_busy;
    logic       r_done;
    logic       r_success;
    logic [2:0] r_fault;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign tick_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_timeout_ms  <= RST_STEP_TIMEOUT;
            r_cfg.pulse_gap_min_ms <= RST_GAP_MIN;
            r_cfg.pulse_gap_max_ms <= RST_GAP_MAX;
            r_cfg.loss_gap_ms      <= RST_LOSS_GAP;
            r_cfg.test_drain_ms    <= RST_TEST_DRAIN;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_STEP_TIMEOUT: r_cfg.step_timeout_ms  <= i_cfg.data;
                REG_GAP_MIN:      r_cfg.pulse_gap_min_ms <= i_cfg.data[7:0];
                REG_GAP_MAX:      r_cfg.pulse_gap_max_ms <= i_cfg.data[7:0];
                REG_LOSS_GAP:     r_cfg.loss_gap_ms      <= i_cfg.data[7:0];
                REG_TEST_DRAIN:   r_cfg.test_drain_ms    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    pss_fb_det u_fb_det (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (tick_acc),
        .i_cfg     (r_cfg),
        .i_pulse   (i_in.feedback_pulse),
        .o_fb_next (fb_next)
    );

    pss_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (tick_acc),
        .i_cfg      (r_cfg),
        .i_fb       (fb_next),
        .i_water    (i_in.water_present),
        .i_cancel   (i_in.cancel),
        .i_opcode   (i_in.opcode),
        .i_drain_ms (i_in.drain_ms),
        .o_res      (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded with each accepted tick
    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_relay   <= seq_res.relay_drive;
            r_triac   <= seq_res.triac_drive;
            r_fb_ok   <= fb_next;
            r_busy    <= seq_res.busy;
            r_done    <= seq_res.done;
            r_success <= seq_res.success;
            r_fault   <= seq_res.fault_code;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.relay_drive = r_relay;
    assign o_out.triac_drive = r_triac;
    assign o_out.feedback_ok = r_fb_ok;
    assign o_out.busy_res    = r_busy;
    assign o_out.done_res    = r_done;
    assign o_out.success     = r_success;
    assign o_out.fault_code  = r_fault;

endmodule

`default_nettype wire

// ===== sv/pss_fb_det.sv =====
// pump switch sequencer: feedback pulse gap detector
// depends on pss_pkg; gives the flag after this beat's update
`default_nettype none

module pss_fb_det
    import pss_pkg::*;
(
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_en,
    input  wire  t_cfg i_cfg,
    input  wire  logic i_pulse,
    output logic       o_fb_next
);

    logic [7:0] r_gap;
    logic       r_flag;
    logic [7:0] n_gap;
    logic       n_flag;
    logic [7:0] gap_inc;
    logic       gap_hit;

    always_comb begin
        gap_inc = (r_gap != GAP_SAT) ? r_gap + 8'd1 : r_gap;
        gap_hit = (gap_inc >= i_cfg.pulse_gap_min_ms) && (gap_inc <= i_cfg.pulse_gap_max_ms);
        n_gap   = gap_inc;
        n_flag  = r_flag;
        if (i_pulse) begin
            if (gap_hit) begin
                n_flag = 1'b1;
            end
            n_gap = 8'd0;
        end
        // silence too long: feedback lost
        if (n_gap >= i_cfg.loss_gap_ms) begin
            n_flag = 1'b0;
        end
    end

    assign o_fb_next = n_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap  <= GAP_SAT;
            r_flag <= 1'b0;
        end else if (i_en) begin
            r_gap  <= n_gap;
            r_flag <= n_flag;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pss_seq.sv =====
// pump switch sequencer: command state machine with relay and triac steps
// depends on pss_pkg; acts on the updated feedback flag from pss_fb_det
`default_nettype none

module pss_seq
    import pss_pkg::*;
(
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_en,
    input  wire  t_cfg        i_cfg,
    input  wire  logic        i_fb,
    input  wire  logic        i_water,
    input  wire  logic        i_cancel,
    input  wire  logic [2:0]  i_opcode,
    input  wire  logic [15:0] i_drain_ms,
    output t_seq_res          o_res
);

    t_state      r_state,   n_state;
    logic [2:0]  r_op,      n_op;
    logic [15:0] r_wait,    n_wait;
    logic [15:0] r_hold,    n_hold;
    logic        r_relay,   n_relay;
    logic        r_triac,   n_triac;
    logic        r_aborted, n_aborted;
    logic [2:0]  r_fault,   n_fault;
    logic        n_done;
    logic        n_success;
    logic [15:0] wait_inc;
    logic        timed_out;

    always_comb begin
        wait_inc  = (r_wait != WAIT_SAT) ? r_wait + 16'd1 : r_wait;
        timed_out = wait_inc >= i_cfg.step_timeout_ms;
    end

    // next state and registers
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_wait    = r_wait;
        n_hold    = r_hold;
        n_relay   = r_relay;
        n_triac   = r_triac;
        n_aborted = r_aborted;
        n_fault   = r_fault;
        n_done    = 1'b0;
        n_success = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_opcode inside {[OP_ENABLE:OP_TEST]}) begin
                    n_fault   = FLT_NONE;
                    n_aborted = 1'b0;
                    n_op      = i_opcode;
                    n_hold    = (i_opcode == OP_TEST) ? i_cfg.test_drain_ms : i_drain_ms;
                    n_wait    = 16'd0;
                    if (i_opcode == OP_DISABLE) begin
                        n_triac = 1'b0;
                        n_state = ST_TRIAC_OFF;
                    end else if (i_opcode == OP_DRAIN_WET && !i_water) begin
                        n_done    = 1'b1;
                        n_success = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_relay = 1'b1;
                        n_state = ST_RELAY_ON;
                    end
                end
            end
            ST_RELAY_ON: begin
                if (i_fb) begin
                    n_triac = 1'b1;
                    n_state = ST_TRIAC_ON;
                    n_wait  = 16'd0;
                end else if (timed_out) begin
                    n_done  = 1'b1;
                    n_fault = FLT_NO_FB_RELAY;
                    n_state = ST_IDLE;
                    n_wait  = 16'd0;
                end else begin
                    n_wait = wait_inc;
                end
            end
            ST_TRIAC_ON: begin
                // triac shorts the sense path, so feedback must vanish
                if (!i_fb) begin
                    n_wait = 16'd0;
                    if (r_op == OP_ENABLE) begin
                        n_done    = 1'b1;
                        n_success = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_state = ST_WATER;
                    end
                end else if (timed_out) begin
                    n_done  = 1'b1;
                    n_fault = FLT_FB_TRIAC_ON;
                    n_state = ST_IDLE;
                    n_wait  = 16'd0;
                end else begin
                    n_wait = wait_inc;
                end
            end
            ST_WATER, ST_DELAY: begin
                if (i_cancel) begin
                    n_wait = 16'd0;
                    if (r_op == OP_TEST) begin
                        // self-test abort drops only the relay
                        n_relay = 1'b0;
                        n_done  = 1'b1;
                        n_fault = FLT_CANCELLED;
                        n_state = ST_IDLE;
                    end else begin
                        n_aborted = 1'b1;
                        n_triac   = 1'b0;
                        n_state   = ST_TRIAC_OFF;
                    end
                end else if (r_state == ST_WATER) begin
                    if (!i_water) begin
                        n_state = ST_DELAY;
                        n_wait  = 16'd0;
                    end
                end else if (r_wait >= r_hold) begin
                    n_triac = 1'b0;
                    n_state = ST_TRIAC_OFF;
                    n_wait  = 16'd0;
                end else begin
                    n_wait = r_wait + 16'd1;
                end
            end
            ST_TRIAC_OFF: begin
                if (i_fb) begin
                    n_relay = 1'b0;
                    n_state = ST_RELAY_OFF;
                    n_wait  = 16'd0;
                end else if (timed_out) begin
                    n_done  = 1'b1;
                    n_fault = FLT_NO_FB_TRIAC;
                    n_state = ST_IDLE;
                    n_wait  = 16'd0;
                end else begin
                    n_wait = wait_inc;
                end
            end
            ST_RELAY_OFF: begin
                if (!i_fb) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                    n_wait  = 16'd0;
                    if (r_aborted) begin
                        n_fault = FLT_CANCELLED;
                    end else begin
                        n_success = 1'b1;
                    end
                end else if (timed_out) begin
                    n_done  = 1'b1;
                    n_fault = FLT_FB_RELAY_OFF;
                    n_state = ST_IDLE;
                    n_wait  = 16'd0;
                end else begin
                    n_wait = wait_inc;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_wait  = 16'd0;
            end
        endcase
    end

    // result of this beat
    always_comb begin
        o_res.relay_drive = n_relay;
        o_res.triac_drive = n_triac;
        o_res.busy        = (n_state != ST_IDLE);
        o_res.done        = n_done;
        o_res.success     = n_success;
        o_res.fault_code  = n_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_op      <= OP_NONE;
            r_wait    <= 16'd0;
            r_hold    <= 16'd0;
            r_relay   <= 1'b0;
            r_triac   <= 1'b0;
            r_aborted <= 1'b0;
            r_fault   <= FLT_NONE;
        end else if (i_en) begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_wait    <= n_wait;
            r_hold    <= n_hold;
            r_relay   <= n_relay;
            r_triac   <= n_triac;
            r_aborted <= n_aborted;
            r_fault   <= n_fault;
        end
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && n_done |=> r_state == ST_IDLE)
        else $error("finished command did not return to idle");

    a_success_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && n_success |=> r_fault == FLT_NONE)
        else $error("successful command left a fault code");

    a_drives_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_relay) && $stable(r_triac) && $stable(r_state))
        else $error("drives moved without a tick");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && n_done && r_state == ST_IDLE |-> i_opcode == OP_DRAIN_WET)
        else $error("command finished on its accept tick unexpectedly");

endmodule

`default_nettype wire

// ===== test/pump_switch_sequencer_with_feedback_test.sv =====
`timescale 1ns / 1ps
// testbench for pump_switch_sequencer_with_feedback: feeds millisecond ticks from a pump plant
// model and checks every result beat against a predictor of the sequencer
// depends on pss_pkg, pss_if and the block's rtl

module pump_switch_sequencer_with_feedback_test;
    import pss_pkg::*;

    localparam int PHASE_CNT       = 8;
    localparam int TICKS_PER_PHASE = 204;
    localparam int SETTLE_CYCLES   = 4;
    localparam int LIMIT_NS        = 5_000_000;

    // opcodes outside the command set, ignored by the block
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        pulse;
        logic        water;
        logic        cancel;
        logic [2:0]  opcode;
        logic [15:0] drain_ms;
    } pump_tick_t;

    typedef struct packed {
        logic       relay;
        logic       triac;
        logic       fb_ok;
        logic       busy;
        logic       done;
        logic       success;
        logic [2:0] fault;
    } pump_out_t;

    typedef struct packed {
        t_state      seq;
        logic [2:0]  run_op;
        logic [15:0] wait_cnt;
        logic [7:0]  gap_cnt;
        logic        fb;
        logic        relay;
        logic        triac;
        logic [2:0]  fault;
        logic [15:0] hold;
        logic        aborted;
    } pump_model_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #4 i_clk = ~i_clk;

    pss_in_if  tick_if ();
    pss_out_if res_if ();
    pss_cfg_if reg_if ();

    pump_switch_sequencer_with_feedback i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (res_if),
        .i_cfg   (reg_if)
    );

    t_cfg        pump_cfg;
    pump_model_t pump_now;     // follows the beats the block accepts
    pump_model_t pump_plan;    // runs ahead as ticks are generated
    pump_tick_t  ticks_pending[$];
    pump_out_t   outputs_due[$];
    int          ticks_queued;
    int          ticks_taken;
    int          error_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        tick_fire;

    // pump plant state
    logic   water_lvl;
    logic   plant_broken;
    t_state last_plan_seq;
    int     quiet_ms;
    int     next_gap;

    function automatic pump_model_t model_at_reset();
        pump_model_t m;
        m = '0;
        m.seq = ST_IDLE;
        m.gap_cnt = GAP_SAT;
        return m;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == WAIT_SAT) ? v : v + 16'd1;
    endfunction

    task automatic advance_pump(inout pump_model_t m, input pump_tick_t t, output pump_out_t r);
        logic       done;
        logic       ok;
        logic [2:0] end_fault;
        done = 1'b0;
        ok = 1'b0;
        end_fault = FLT_NONE;

        // feedback detector runs before the sequencer
        if (m.gap_cnt != GAP_SAT)
            m.gap_cnt = m.gap_cnt + 8'd1;
        if (t.pulse) begin
            if (m.gap_cnt >= pump_cfg.pulse_gap_min_ms && m.gap_cnt <= pump_cfg.pulse_gap_max_ms)
                m.fb = 1'b1;
            m.gap_cnt = 8'd0;
        end
        if (m.fb && m.gap_cnt >= pump_cfg.loss_gap_ms)
            m.fb = 1'b0;

        if (t.cancel && (m.seq == ST_WATER || m.seq == ST_DELAY)) begin
            if (m.run_op == OP_TEST) begin
                // self-test abort drops the relay only
                m.relay = 1'b0;
                done = 1'b1;
                end_fault = FLT_CANCELLED;
            end else begin
                m.aborted = 1'b1;
                m.triac = 1'b0;
                m.seq = ST_TRIAC_OFF;
                m.wait_cnt = 16'd0;
            end
        end else begin
            case (m.seq)
                ST_IDLE: begin
                    if (t.opcode >= OP_ENABLE && t.opcode <= OP_TEST) begin
                        m.fault = FLT_NONE;
                        m.aborted = 1'b0;
                        m.run_op = t.opcode;
                        m.hold = (t.opcode == OP_TEST) ? pump_cfg.test_drain_ms : t.drain_ms;
                        if (t.opcode == OP_DISABLE) begin
                            m.triac = 1'b0;
                            m.seq = ST_TRIAC_OFF;
                            m.wait_cnt = 16'd0;
                        end else if (t.opcode == OP_DRAIN_WET && !t.water) begin
                            done = 1'b1;
                            ok = 1'b1;
                        end else begin
                            m.relay = 1'b1;
                            m.seq = ST_RELAY_ON;
                            m.wait_cnt = 16'd0;
                        end
                    end
                end
                ST_RELAY_ON: begin
                    if (m.fb) begin
                        m.triac = 1'b1;
                        m.seq = ST_TRIAC_ON;
                        m.wait_cnt = 16'd0;
                    end else begin
                        m.wait_cnt = sat_inc(m.wait_cnt);
                        if (m.wait_cnt >= pump_cfg.step_timeout_ms) begin
                            done = 1'b1;
                            end_fault = FLT_NO_FB_RELAY;
                        end
                    end
                end
                ST_TRIAC_ON: begin
                    if (!m.fb) begin
                        if (m.run_op == OP_ENABLE) begin
                            done = 1'b1;
                            ok = 1'b1;
                        end else begin
                            m.seq = ST_WATER;
                            m.wait_cnt = 16'd0;
                        end
                    end else begin
                        m.wait_cnt = sat_inc(m.wait_cnt);
                        if (m.wait_cnt >= pump_cfg.step_timeout_ms) begin
                            done = 1'b1;
                            end_fault = FLT_FB_TRIAC_ON;
                        end
                    end
                end
                ST_WATER: begin
                    if (!t.water) begin
                        m.seq = ST_DELAY;
                        m.wait_cnt = 16'd0;
                    end
                end
                ST_DELAY: begin
                    if (m.wait_cnt >= m.hold) begin
                        m.triac = 1'b0;
                        m.seq = ST_TRIAC_OFF;
                        m.wait_cnt = 16'd0;
                    end else begin
                        m.wait_cnt = m.wait_cnt + 16'd1;
                    end
                end
                ST_TRIAC_OFF: begin
                    if (m.fb) begin
                        m.relay = 1'b0;
                        m.seq = ST_RELAY_OFF;
                        m.wait_cnt = 16'd0;
                    end else begin
                        m.wait_cnt = sat_inc(m.wait_cnt);
                        if (m.wait_cnt >= pump_cfg.step_timeout_ms) begin
                            done = 1'b1;
                            end_fault = FLT_NO_FB_TRIAC;
                        end
                    end
                end
                ST_RELAY_OFF: begin
                    if (!m.fb) begin
                        done = 1'b1;
                        ok = !m.aborted;
                        end_fault = m.aborted ? FLT_CANCELLED : FLT_NONE;
                    end else begin
                        m.wait_cnt = sat_inc(m.wait_cnt);
                        if (m.wait_cnt >= pump_cfg.step_timeout_ms) begin
                            done = 1'b1;
                            end_fault = FLT_FB_RELAY_OFF;
                        end
                    end
                end
                default: begin
                    m.seq = ST_IDLE;
                    m.wait_cnt = 16'd0;
                end
            endcase
        end

        if (done) begin
            m.fault = end_fault;
            m.seq = ST_IDLE;
            m.wait_cnt = 16'd0;
        end

        r.relay = m.relay;
        r.triac = m.triac;
        r.fb_ok = m.fb;
        r.busy = (m.seq != ST_IDLE);
        r.done = done;
        r.success = done && ok;
        r.fault = m.fault;
    endtask

    task automatic flag_mismatch(input string msg);
        error_cnt++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_beat(input pump_out_t got);
        pump_out_t want;
        if (outputs_due.size() == 0) begin
            flag_mismatch("result beat with no tick outstanding");
        end else begin
            want = outputs_due.pop_front();
            check_field("relay_drive", 3'(got.relay), 3'(want.relay));
            check_field("triac_drive", 3'(got.triac), 3'(want.triac));
            check_field("feedback_ok", 3'(got.fb_ok), 3'(want.fb_ok));
            check_field("busy_res", 3'(got.busy), 3'(want.busy));
            check_field("done_res", 3'(got.done), 3'(want.done));
            check_field("success", 3'(got.success), 3'(want.success));
            check_field("fault_code", got.fault, want.fault);
        end
    endtask

    task automatic plan_tick(input pump_tick_t t);
        pump_out_t unused;
        advance_pump(pump_plan, t, unused);
        ticks_pending.push_back(t);
        ticks_queued++;
    endtask

    // one tick of plant behavior: pulses follow what the current step waits for,
    // now and then the plant misbehaves for a whole step
    task automatic make_tick(input logic winding_down);
        pump_tick_t t;
        logic       want;
        logic       waiting;
        t = '0;
        if (pump_plan.seq != last_plan_seq)
            plant_broken = !winding_down && pump_cfg.step_timeout_ms <= 16'd300 &&
                           $urandom_range(9) == 0;
        last_plan_seq = pump_plan.seq;
        case (pump_plan.seq)
            ST_RELAY_ON, ST_TRIAC_OFF: want = !plant_broken;
            ST_TRIAC_ON, ST_RELAY_OFF: want = plant_broken;
            default:                   want = pump_plan.relay && !pump_plan.triac;
        endcase

        if (quiet_ms < 1000)
            quiet_ms++;
        if (want)
            t.pulse = (quiet_ms >= next_gap);
        else
            t.pulse = ($urandom_range(63) == 0);
        if (t.pulse) begin
            quiet_ms = 0;
            if (pump_cfg.pulse_gap_min_ms <= pump_cfg.pulse_gap_max_ms && $urandom_range(6) != 0)
                next_gap = $urandom_range(pump_cfg.pulse_gap_max_ms, pump_cfg.pulse_gap_min_ms);
            else
                next_gap = $urandom_range(30, 1);
        end

        if ($urandom_range(7) == 0)
            water_lvl = !water_lvl;
        t.water = water_lvl;

        waiting = (pump_plan.seq == ST_WATER || pump_plan.seq == ST_DELAY);
        if (waiting && winding_down)
            t.cancel = 1'b1;
        else if (waiting && pump_plan.hold > 16'd100)
            t.cancel = ($urandom_range(9) == 0);
        else
            t.cancel = ($urandom_range(39) == 0);

        if (pump_plan.seq == ST_IDLE && !winding_down && $urandom_range(3) == 0)
            t.opcode = 3'($urandom_range(OP_SPARE_HI, OP_ENABLE));
        else if (pump_plan.seq != ST_IDLE && $urandom_range(3) == 0)
            t.opcode = 3'($urandom_range(OP_SPARE_HI, OP_NONE));
        else
            t.opcode = OP_NONE;

        if ($urandom_range(19) == 0)
            t.drain_ms = 16'($urandom_range(65535));
        else
            t.drain_ms = 16'($urandom_range(40));
        plan_tick(t);
    endtask

    task automatic directed_op(input logic [2:0] op, input logic [15:0] drain);
        pump_tick_t t;
        t = '0;
        t.water = 1'b1;
        t.opcode = op;
        t.drain_ms = drain;
        plan_tick(t);
        // no pulses, so the first step runs out of time; busy ticks try another command
        t.opcode = OP_ENABLE;
        t.cancel = 1'b1;
        repeat (pump_cfg.step_timeout_ms) plan_tick(t);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data <= val;
        @(posedge i_clk);
        while (!reg_if.ready) @(posedge i_clk);
        case (idx)
            REG_STEP_TIMEOUT: pump_cfg.step_timeout_ms = val;
            REG_GAP_MIN:      pump_cfg.pulse_gap_min_ms = val[7:0];
            REG_GAP_MAX:      pump_cfg.pulse_gap_max_ms = val[7:0];
            REG_LOSS_GAP:     pump_cfg.loss_gap_ms = val[7:0];
            REG_TEST_DRAIN:   pump_cfg.test_drain_ms = val;
            default: ;
        endcase
    endtask

    always @(negedge i_clk) begin : drive_ticks
        pump_tick_t t;
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else if (!tick_if.valid || tick_fire) begin
            if (ticks_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t = ticks_pending.pop_front();
                tick_if.valid <= 1'b1;
                tick_if.feedback_pulse <= t.pulse;
                tick_if.water_present <= t.water;
                tick_if.cancel <= t.cancel;
                tick_if.opcode <= t.opcode;
                tick_if.drain_ms <= t.drain_ms;
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : watch_beats
        pump_tick_t t;
        pump_out_t  r;
        pump_out_t  got;
        if (!i_rst_n) begin
            tick_fire <= 1'b0;
        end else begin
            tick_fire <= tick_if.valid && tick_if.ready;
            if (tick_if.valid && tick_if.ready) begin
                t.pulse = tick_if.feedback_pulse;
                t.water = tick_if.water_present;
                t.cancel = tick_if.cancel;
                t.opcode = tick_if.opcode;
                t.drain_ms = tick_if.drain_ms;
                advance_pump(pump_now, t, r);
                outputs_due.push_back(r);
                ticks_taken++;
            end
            if (res_if.valid && res_if.ready) begin
                got.relay = res_if.relay_drive;
                got.triac = res_if.triac_drive;
                got.fb_ok = res_if.feedback_ok;
                got.busy = res_if.busy_res;
                got.done = res_if.done_res;
                got.success = res_if.success;
                got.fault = res_if.fault_code;
                check_beat(got);
            end
        end
    end

    initial begin : run_phases
        t_cfg       next_cfg;
        pump_tick_t t;
        tick_if.valid = 1'b0;
        tick_if.feedback_pulse = 1'b0;
        tick_if.water_present = 1'b0;
        tick_if.cancel = 1'b0;
        tick_if.opcode = OP_NONE;
        tick_if.drain_ms = 16'd0;
        res_if.ready = 1'b0;
        reg_if.valid = 1'b0;
        reg_if.index = REG_STEP_TIMEOUT;
        reg_if.data = 16'd0;
        pump_cfg = {RST_STEP_TIMEOUT, RST_GAP_MIN, RST_GAP_MAX, RST_LOSS_GAP, RST_TEST_DRAIN};
        pump_now = model_at_reset();
        pump_plan = model_at_reset();
        ticks_queued = 0;
        ticks_taken = 0;
        error_cnt = 0;
        water_lvl = 1'b0;
        plant_broken = 1'b0;
        last_plan_seq = ST_IDLE;
        quiet_ms = 1000;
        next_gap = 10;
        send_idle_pct = 19;
        recv_idle_pct = 57;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < PHASE_CNT; ph++) begin
            case (ph)
                0: next_cfg = {16'd4, 8'd8, 8'd12, 8'd13, 16'd0};
                1: next_cfg = {16'd40, 8'd8, 8'd12, 8'd13, 16'd20};
                2: next_cfg = {16'd1, 8'd0, 8'd255, 8'd255, 16'd0};
                3: next_cfg = {16'd65535, 8'd3, 8'd5, 8'd6, 16'd65535};
                4: next_cfg = {16'd0, 8'd12, 8'd8, 8'd1, 16'd5};
                5: next_cfg = {16'd25, 8'd1, 8'd1, 8'd2, 16'd0};
                6: next_cfg = {16'd300, 8'd20, 8'd40, 8'd60, 16'd100};
                default: next_cfg = {RST_STEP_TIMEOUT, RST_GAP_MIN, RST_GAP_MAX, RST_LOSS_GAP,
                                     RST_TEST_DRAIN};
            endcase
            if (ph < 3) begin
                send_idle_pct = 19;
                recv_idle_pct = 57;
            end else if (ph < 6) begin
                send_idle_pct = 57;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            write_reg(REG_STEP_TIMEOUT, next_cfg.step_timeout_ms);
            write_reg(REG_GAP_MIN, {8'd0, next_cfg.pulse_gap_min_ms});
            write_reg(REG_GAP_MAX, {8'd0, next_cfg.pulse_gap_max_ms});
            write_reg(REG_LOSS_GAP, {8'd0, next_cfg.loss_gap_ms});
            write_reg(REG_TEST_DRAIN, next_cfg.test_drain_ms);
            @(negedge i_clk);
            reg_if.valid <= 1'b0;

            if (ph == 0) begin
                // first pulse after reset sees the saturated gap; spare opcodes do nothing
                t = '0;
                t.pulse = 1'b1;
                t.opcode = OP_SPARE_LO;
                plan_tick(t);
                t = '0;
                t.water = 1'b1;
                t.cancel = 1'b1;
                t.opcode = OP_SPARE_HI;
                t.drain_ms = 16'hFFFF;
                plan_tick(t);
                // dry tank: drain-if-water ends on the accept tick
                t = '0;
                t.opcode = OP_DRAIN_WET;
                t.drain_ms = 16'hFFFF;
                plan_tick(t);
                directed_op(OP_DISABLE, 16'd0);
                directed_op(OP_ENABLE, 16'd0);
                directed_op(OP_DRAIN, 16'hFFFF);
                directed_op(OP_TEST, 16'd0);
            end else begin
                repeat (TICKS_PER_PHASE) make_tick(1'b0);
            end
            while (pump_plan.seq != ST_IDLE) make_tick(1'b1);

            // registers change only once every tick and result of the phase is through
            while (ticks_taken != ticks_queued || outputs_due.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end

        if (error_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #LIMIT_NS;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
sv/pss_pkg.sv
sv/pss_if.sv
sv/pss_fb_det.sv
sv/pss_seq.sv
sv/pump_switch_sequencer_with_feedback.sv
test/pump_switch_sequencer_with_feedback_test.sv
